FILE: rtl/core/sbmm_pkg.sv
// Shared widths and defaults for the sum-between-min-and-max block.
`default_nettype none

package sbmm_pkg;

    localparam int DATA_W               = 16;
    localparam int IDX_W                = 10;
    localparam int SUM_W                = 26;
    localparam int DEFAULT_MAX_ELEMENTS = 1024;

endpackage

`default_nettype wire

FILE: rtl/core/sum_between_min_and_max_core.sv
// Top level: sum of stored matrix elements between first minimum and first maximum.
//
// Input channel (s_valid/s_ready): one matrix element per request, row-major,
// s_is_last marking the final one. While loading, one element is taken every
// cycle and written to the element RAM; min/max tracking runs alongside.
// Elements past MAX_ELEMENTS are not stored and set m_overflowed.
// After the last element, s_ready drops while a sequencer walks the RAM from
// the lower to the higher of the two indices, one entry per cycle through a
// single adder; the result register is loaded after the start state, the RAM
// read, the final add, the done flag and the hand-off to the output register.
// Result channel (m_valid/m_ready): one request per matrix, held in an output
// register. Loading of the next matrix starts as soon as the result is
// registered; a stalled receiver only holds the block once another matrix
// finishes summing while the previous result is still pending.
// Reset (aresetn, synchronous, active low) clears the counters, trackers and
// handshake state; RAM contents are not cleared and need not be.
`default_nettype none

module sum_between_min_and_max_core #(
    parameter int MAX_ELEMENTS = sbmm_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [sbmm_pkg::DATA_W-1:0] s_element,
    input  wire logic                               s_is_last,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed      [sbmm_pkg::DATA_W-1:0] m_min_value,
    output logic signed      [sbmm_pkg::DATA_W-1:0] m_max_value,
    output logic             [sbmm_pkg::IDX_W-1:0]  m_min_index,
    output logic             [sbmm_pkg::IDX_W-1:0]  m_max_index,
    output logic signed      [sbmm_pkg::SUM_W-1:0]  m_range_sum,
    output logic                                    m_overflowed
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_START,
        ST_SUM,
        ST_HOLD
    } state_t;

    state_t state_reg;

    logic                               accept;
    logic                               take;
    logic                               clear;
    logic                               wr_en;
    logic        [AW-1:0]               wr_addr;
    logic        [CW-1:0]               count;
    logic signed [sbmm_pkg::DATA_W-1:0] min_value;
    logic signed [sbmm_pkg::DATA_W-1:0] max_value;
    logic        [AW-1:0]               min_pos;
    logic        [AW-1:0]               max_pos;
    logic                               dropped;
    logic        [AW-1:0]               lo;
    logic        [AW-1:0]               hi;
    logic        [AW-1:0]               rd_addr;
    logic        [sbmm_pkg::DATA_W-1:0] rd_data;
    logic                               sum_start;
    logic                               sum_done;
    logic        [sbmm_pkg::SUM_W-1:0]  sum;
    logic                               out_free;

    logic                               m_valid_reg;
    logic signed [sbmm_pkg::DATA_W-1:0] min_value_reg;
    logic signed [sbmm_pkg::DATA_W-1:0] max_value_reg;
    logic        [sbmm_pkg::IDX_W-1:0]  min_index_reg;
    logic        [sbmm_pkg::IDX_W-1:0]  max_index_reg;
    logic        [sbmm_pkg::SUM_W-1:0]  range_sum_reg;
    logic                               overflowed_reg;

    assign s_ready   = (state_reg == ST_LOAD);
    assign accept    = s_valid && s_ready;
    assign take      = accept;
    assign out_free  = !m_valid_reg || m_ready;
    assign clear     = (state_reg == ST_HOLD) && out_free;
    assign sum_start = (state_reg == ST_START);
    assign lo        = (min_pos < max_pos) ? min_pos : max_pos;
    assign hi        = (min_pos < max_pos) ? max_pos : min_pos;

    sbmm_track #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW),
        .CW           (CW)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .clear     (clear),
        .element   (s_element),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .count     (count),
        .min_value (min_value),
        .max_value (max_value),
        .min_pos   (min_pos),
        .max_pos   (max_pos),
        .dropped   (dropped)
    );

    sbmm_ram #(
        .WIDTH (sbmm_pkg::DATA_W),
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_element),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbmm_sum #(
        .AW (AW)
    ) u_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sum_start),
        .lo      (lo),
        .hi      (hi),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (sum_done),
        .sum     (sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !clear) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (accept && s_is_last) begin
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (sum_done) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        min_value_reg  <= min_value;
                        max_value_reg  <= max_value;
                        min_index_reg  <= sbmm_pkg::IDX_W'(min_pos);
                        max_index_reg  <= sbmm_pkg::IDX_W'(max_pos);
                        range_sum_reg  <= sum;
                        overflowed_reg <= dropped;
                        state_reg      <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_min_value  = min_value_reg;
    assign m_max_value  = max_value_reg;
    assign m_min_index  = min_index_reg;
    assign m_max_index  = max_index_reg;
    assign m_range_sum  = range_sum_reg;
    assign m_overflowed = overflowed_reg;

    a_done_in_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_done |-> state_reg == ST_SUM)
        else $error("sum done outside summing phase");

    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_is_last |=> state_reg == ST_START)
        else $error("last element did not start summing");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count != '0 |-> min_value <= max_value)
        else $error("running minimum above running maximum");

endmodule

`default_nettype wire

FILE: rtl/core/sbmm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none

module sbmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/sbmm_track.sv
// Element counter and first-minimum / first-maximum tracker.
`default_nettype none

module sbmm_track #(
    parameter int MAX_ELEMENTS = sbmm_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    parameter int CW           = $clog2(MAX_ELEMENTS + 1)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              take,
    input  wire logic                              clear,
    input  wire logic signed [sbmm_pkg::DATA_W-1:0] element,
    output logic                                   wr_en,
    output logic             [AW-1:0]              wr_addr,
    output logic             [CW-1:0]              count,
    output logic signed      [sbmm_pkg::DATA_W-1:0] min_value,
    output logic signed      [sbmm_pkg::DATA_W-1:0] max_value,
    output logic             [AW-1:0]              min_pos,
    output logic             [AW-1:0]              max_pos,
    output logic                                   dropped
);

    logic                                   full;
    logic             [CW-1:0]              count_reg;
    logic signed      [sbmm_pkg::DATA_W-1:0] min_reg;
    logic signed      [sbmm_pkg::DATA_W-1:0] max_reg;
    logic             [AW-1:0]              min_pos_reg;
    logic             [AW-1:0]              max_pos_reg;
    logic                                   drop_reg;

    assign full    = (count_reg == CW'(MAX_ELEMENTS));
    assign wr_en   = take && !full;
    assign wr_addr = count_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            count_reg   <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            min_pos_reg <= '0;
            max_pos_reg <= '0;
            drop_reg    <= 1'b0;
        end else if (take) begin
            if (!full) begin
                if (count_reg == '0) begin
                    min_reg     <= element;
                    max_reg     <= element;
                    min_pos_reg <= '0;
                    max_pos_reg <= '0;
                end else begin
                    if (element < min_reg) begin
                        min_reg     <= element;
                        min_pos_reg <= count_reg[AW-1:0];
                    end
                    if (element > max_reg) begin
                        max_reg     <= element;
                        max_pos_reg <= count_reg[AW-1:0];
                    end
                end
                count_reg <= count_reg + 1'b1;
            end else begin
                drop_reg <= 1'b1;
            end
        end
    end

    assign count     = count_reg;
    assign min_value = min_reg;
    assign max_value = max_reg;
    assign min_pos   = min_pos_reg;
    assign max_pos   = max_pos_reg;
    assign dropped   = drop_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sbmm_sum.sv
// Range summing sequencer: walks the store from lo to hi through one adder.
`default_nettype none

module sbmm_sum #(
    parameter int AW = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic        [AW-1:0]               lo,
    input  wire logic        [AW-1:0]               hi,
    output logic             [AW-1:0]               rd_addr,
    input  wire logic signed [sbmm_pkg::DATA_W-1:0] rd_data,
    output logic                                    done,
    output logic             [sbmm_pkg::SUM_W-1:0]  sum
);

    logic [AW-1:0]              addr_reg;
    logic [AW-1:0]              hi_reg;
    logic                       issue_reg;
    logic                       pend_reg;
    logic                       done_reg;
    logic [sbmm_pkg::SUM_W-1:0] acc_reg;

    assign rd_addr = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= pend_reg && !issue_reg;
            pend_reg <= issue_reg;
            if (start) begin
                issue_reg <= 1'b1;
            end else if (issue_reg && addr_reg == hi_reg) begin
                issue_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            addr_reg <= lo;
            hi_reg   <= hi;
            acc_reg  <= '0;
        end else begin
            if (issue_reg) begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (pend_reg) begin
                acc_reg <= acc_reg + sbmm_pkg::SUM_W'(rd_data);
            end
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Testbench for sum_between_min_and_max_core: directed table plus random matrices.
module tb;

    localparam int DATA_W       = sbmm_pkg::DATA_W;
    localparam int IDX_W        = sbmm_pkg::IDX_W;
    localparam int SUM_W        = sbmm_pkg::SUM_W;
    localparam int CAPACITY     = sbmm_pkg::DEFAULT_MAX_ELEMENTS;
    localparam int RANDOM_ITEMS = 1300;
    localparam int GAP_MAX      = 17;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic        [IDX_W-1:0]  min_index;
        logic        [IDX_W-1:0]  max_index;
        logic signed [SUM_W-1:0]  range_sum;
        logic                     overflowed;
    } sum_result_t;

    typedef struct {
        logic signed [DATA_W-1:0] element;
        bit                       is_last;
        bit                       typed;
        sum_result_t              want;
    } stim_row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic signed [DATA_W-1:0] s_element = '0;
    logic                     s_is_last = 1'b0;
    logic                     m_ready   = 1'b0;
    logic                     s_ready;
    logic                     m_valid;
    logic signed [DATA_W-1:0] m_min_value;
    logic signed [DATA_W-1:0] m_max_value;
    logic        [IDX_W-1:0]  m_min_index;
    logic        [IDX_W-1:0]  m_max_index;
    logic signed [SUM_W-1:0]  m_range_sum;
    logic                     m_overflowed;

    sum_between_min_and_max_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_element    (s_element),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_min_value  (m_min_value),
        .m_max_value  (m_max_value),
        .m_min_index  (m_min_index),
        .m_max_index  (m_max_index),
        .m_range_sum  (m_range_sum),
        .m_overflowed (m_overflowed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state: one matrix in progress
    logic signed [DATA_W-1:0] mat_store [CAPACITY];
    int                       mat_count;
    logic signed [DATA_W-1:0] run_min;
    logic signed [DATA_W-1:0] run_max;
    int                       min_pos;
    int                       max_pos;
    bit                       dropped;

    sum_result_t pending_sums [$];
    int          error_count   = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          overflow_runs = 0;
    int          cycle_count   = 0;
    int          src_mode      = 0;
    int          sink_mode     = 0;

    function automatic void clear_tracker();
        mat_count = 0;
        run_min   = '0;
        run_max   = '0;
        min_pos   = 0;
        max_pos   = 0;
        dropped   = 1'b0;
    endfunction

    // returns 1 when the element closes the matrix, with its result in res
    function automatic bit track_element(input logic signed [DATA_W-1:0] e, input bit is_last,
                                         output sum_result_t res);
        int lo;
        int hi;
        logic signed [SUM_W-1:0] acc;
        res = '0;
        if (mat_count < CAPACITY) begin
            mat_store[mat_count] = e;
            if (mat_count == 0) begin
                run_min = e;
                run_max = e;
                min_pos = 0;
                max_pos = 0;
            end else begin
                if (e < run_min) begin
                    run_min = e;
                    min_pos = mat_count;
                end
                if (e > run_max) begin
                    run_max = e;
                    max_pos = mat_count;
                end
            end
            mat_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!is_last)
            return 1'b0;
        lo  = (min_pos < max_pos) ? min_pos : max_pos;
        hi  = (min_pos < max_pos) ? max_pos : min_pos;
        acc = '0;
        for (int i = lo; i <= hi && i < mat_count; i++)
            acc += SUM_W'(mat_store[i]);
        res.min_value  = run_min;
        res.max_value  = run_max;
        res.min_index  = min_pos[IDX_W-1:0];
        res.max_index  = max_pos[IDX_W-1:0];
        res.range_sum  = acc;
        res.overflowed = dropped;
        clear_tracker();
        return 1'b1;
    endfunction

    function automatic stim_row_t plain(input int e, input bit is_last);
        stim_row_t r;
        r.element = DATA_W'(e);
        r.is_last = is_last;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    // closing element of a matrix with a hand-written result, no overflow
    function automatic stim_row_t known(input int e, input int mn, input int mx,
                                        input int mni, input int mxi, input int total);
        stim_row_t r;
        r.element         = DATA_W'(e);
        r.is_last         = 1'b1;
        r.typed           = 1'b1;
        r.want.min_value  = DATA_W'(mn);
        r.want.max_value  = DATA_W'(mx);
        r.want.min_index  = IDX_W'(mni);
        r.want.max_index  = IDX_W'(mxi);
        r.want.range_sum  = SUM_W'(total);
        r.want.overflowed = 1'b0;
        return r;
    endfunction

    function automatic int draw_gap(input int mode);
        case (mode)
            1:       return 0;
            2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : 0;
            default: return $urandom_range(0, GAP_MAX);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_element(input int mode);
        case (mode)
            1:       return DATA_W'($urandom_range(0, 6) - 3);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_element(input stim_row_t r);
        int          gap;
        sum_result_t res;
        gap = draw_gap(src_mode);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_element = r.element;
        s_is_last = r.is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (track_element(r.element, r.is_last, res))
            pending_sums.push_back(r.typed ? r.want : res);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic note_error(input string what, input sum_result_t want, input sum_result_t got);
        error_count++;
        if (error_count <= 10)
            $display({"ERROR %s: min %0d/%0d max %0d/%0d min_idx %0d/%0d max_idx %0d/%0d",
                      " sum %0d/%0d ovf %0b/%0b (exp/got)"},
                     what, want.min_value, got.min_value, want.max_value, got.max_value,
                     want.min_index, got.min_index, want.max_index, got.max_index,
                     want.range_sum, got.range_sum, want.overflowed, got.overflowed);
    endtask

    always @(posedge aclk) begin : result_check
        sum_result_t got;
        sum_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_min_value, m_max_value, m_min_index, m_max_index, m_range_sum, m_overflowed};
            results_seen++;
            if (pending_sums.size() == 0) begin
                note_error("unexpected request", '0, got);
            end else begin
                want = pending_sums.pop_front();
                if (got.min_value !== want.min_value || got.max_value !== want.max_value ||
                    got.min_index !== want.min_index || got.max_index !== want.max_index ||
                    got.range_sum !== want.range_sum || got.overflowed !== want.overflowed)
                    note_error("mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_sums.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 9) == 0)
                sink_mode = $urandom_range(0, 2);
            stall = draw_gap(sink_mode);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        stim_row_t                rows [];
        int                       len;
        int                       pick;
        int                       big_at;
        int                       n;
        bit                       big_done;
        logic signed [DATA_W-1:0] e;

        clear_tracker();
        big_done = 1'b0;
        rows = {
            known(-32768, -32768, -32768, 0, 0, -32768),
            known(32767, 32767, 32767, 0, 0, 32767),
            known(0, 0, 0, 0, 0, 0),
            plain(5, 1'b0), plain(-32768, 1'b0), plain(32767, 1'b0),
            known(7, -32768, 32767, 1, 2, -1),
            plain(3, 1'b0), plain(3, 1'b0),
            known(3, 3, 3, 0, 0, 3),
            plain(32767, 1'b0), plain(1, 1'b0),
            known(-32768, -32768, 32767, 2, 0, 0),
            plain(-5, 1'b0), plain(9, 1'b0), plain(-5, 1'b0),
            known(9, -5, 9, 0, 1, 4),
            plain(100, 1'b0), plain(-200, 1'b0), plain(300, 1'b0), plain(-400, 1'b0),
            plain(50, 1'b1)
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i])
            send_element(rows[i]);

        // one matrix overruns the store, placed early in the random part
        big_at = rows.size() + $urandom_range(100, 250);
        while (items_sent < rows.size() + RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                src_mode = $urandom_range(0, 2);
            if (!big_done && items_sent >= big_at) begin
                n = CAPACITY + $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    if (k == CAPACITY - 1) begin
                        e = 16'sh8000;
                    end else begin
                        e = rand_element(0);
                        if (k < CAPACITY && e == 16'sh8000)
                            e = 16'sh8001;
                    end
                    send_element(plain(int'(e), k == n - 1));
                end
                big_done = 1'b1;
                overflow_runs++;
            end else begin
                len  = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
                pick = $urandom_range(0, 2);
                for (int k = 0; k < len; k++)
                    send_element(plain(int'(rand_element(pick)), k == len - 1));
            end
        end
        s_valid = 1'b0;

        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d elements forming %0d matrices; %0d matrix ran past the %0d-entry store",
                 items_sent, results_seen, overflow_runs, CAPACITY);
        $display("Result checks failed: %0d", error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sbmm_pkg.sv
rtl/core/sbmm_ram.sv
rtl/core/sbmm_track.sv
rtl/core/sbmm_sum.sv
rtl/core/sum_between_min_and_max_core.sv
test/tb.sv
